// ===== hw/rtl/nsbh_pkg.sv =====
// Shared constants and types for the nearest segment box hit block.
// No dependencies; imported by every module under hw/rtl.
package nsbh_pkg;

    localparam int BOX_COUNT       = 16;
    localparam int PARAM_FRAC_BITS = 16;
    localparam int CW  = 32;
    localparam int DW  = CW + 3;
    localparam int IW  = 4;
    localparam int PW  = 17;
    localparam int TW  = PARAM_FRAC_BITS + 1;
    localparam int NW  = PARAM_FRAC_BITS + 2;
    localparam int BW  = (BOX_COUNT > 1) ? $clog2(BOX_COUNT) : 1;

    localparam logic [NW-1:0] ONE_T = NW'(1) << PARAM_FRAC_BITS;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_PROBE = 1'b1;

    typedef struct packed {
        logic                        valid;
        logic                        open;
        logic signed [2:0][CW-1:0]   lo;
        logic signed [2:0][CW-1:0]   hi;
    } t_box;

endpackage

// ===== hw/rtl/nsbh_cell.sv =====
// One box entry of the rotating box ring.
// Depends on nsbh_pkg for t_box.
module nsbh_cell import nsbh_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_shift,
    input  logic i_write,
    input  t_box i_next,
    input  t_box i_wdata,
    output t_box o_box
);

    t_box r_box;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box.valid <= 1'b0;
        end else if (i_write) begin
            r_box <= i_wdata;
        end else if (i_shift) begin
            r_box <= i_next;
        end
    end

    assign o_box = r_box;

endmodule

// ===== hw/rtl/nsbh_div.sv =====
// Restoring divider, one quotient bit per step, for slab parameters.
// Depends on nsbh_pkg for widths.
module nsbh_div import nsbh_pkg::*; (
    input  logic          i_clk,
    input  logic          i_load,
    input  logic          i_step,
    input  logic [DW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [TW-1:0] o_quot,
    output logic          o_rem_nz
);

    logic [DW-1:0] r_rem, n_rem, w_dbl;
    logic [TW-1:0] r_quot, n_quot;
    logic          w_ge;

    always_comb begin
        w_ge   = i_num >= i_den;
        w_dbl  = {r_rem[DW-2:0], 1'b0};
        n_rem  = r_rem;
        n_quot = r_quot;
        if (i_load) begin
            n_rem  = w_ge ? i_num - i_den : i_num;
            n_quot = TW'(w_ge);
        end else if (i_step) begin
            if (w_dbl >= i_den) begin
                n_rem  = w_dbl - i_den;
                n_quot = {r_quot[TW-2:0], 1'b1};
            end else begin
                n_rem  = w_dbl;
                n_quot = {r_quot[TW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_quot <= n_quot;
    end

    assign o_quot   = r_quot;
    assign o_rem_nz = r_rem != '0;

endmodule

// ===== hw/rtl/nearest_segment_box_hit.sv =====
// Top level: box ring, shared per-axis slab dividers and hit sequencer.
// Depends on nsbh_pkg, nsbh_cell and nsbh_div.
//
// Usage: one input channel (i_in_valid / o_in_stall) carries write and
// probe words; one output channel (o_out_valid / i_out_stall) returns
// exactly one result word per input word, in order.
// A write word loads one box entry; its all-zero result goes to the
// output register from the result state once that register is free.
// A probe word rotates the 16-entry box ring past a slab unit of six
// restoring dividers (near and far per axis). Each box passes through
// one load, PARAM_FRAC_BITS divider steps and one evaluate. After the
// last box, the multiply and finish states form the probe result.
// One word is in work at a time; o_in_stall is high until its result
// moves into the output register.
// When the receiver stalls, the output register holds its word; a new
// input word is still taken and worked on, and its result waits in the
// sequencer until the output register frees.
// Reset (synchronous, active low) clears all box valid bits, the
// sequencer and the output valid. Box contents are not cleared.
module nearest_segment_box_hit import nsbh_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_action,
    input  logic [IW-1:0]        i_box_index,
    input  logic signed [CW-1:0] i_point_a_x,
    input  logic signed [CW-1:0] i_point_a_y,
    input  logic signed [CW-1:0] i_point_a_z,
    input  logic signed [CW-1:0] i_point_b_x,
    input  logic signed [CW-1:0] i_point_b_y,
    input  logic signed [CW-1:0] i_point_b_z,
    input  logic                 i_box_open,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_hit_flag,
    output logic [IW-1:0]        o_hit_entry,
    output logic [PW-1:0]        o_hit_param,
    output logic [1:0]           o_hit_axis,
    output logic                 o_normal_negative,
    output logic signed [CW-1:0] o_contact_x,
    output logic signed [CW-1:0] o_contact_y,
    output logic signed [CW-1:0] o_contact_z,
    output logic signed [CW-1:0] o_push_x,
    output logic signed [CW-1:0] o_push_y,
    output logic signed [CW-1:0] o_push_z
);

    localparam int PRW = DW + NW + 1;
    localparam int SW  = (PARAM_FRAC_BITS > 1) ? $clog2(PARAM_FRAC_BITS) : 1;
    localparam logic signed [PRW-1:0] HALF  = PRW'(1) << (PARAM_FRAC_BITS - 1);
    localparam logic signed [PRW-1:0] P_MAX = PRW'({1'b0, {(CW-1){1'b1}}});
    localparam logic signed [PRW-1:0] P_MIN = -P_MAX - PRW'(1);

    typedef enum logic [2:0] {
        S_IDLE, S_LOAD, S_DIV, S_EVAL, S_MUL, S_FIN, S_RESULT
    } t_state;

    typedef struct packed {
        logic                      hit_flag;
        logic [IW-1:0]             entry;
        logic [PW-1:0]             param;
        logic [1:0]                axis;
        logic                      neg;
        logic signed [2:0][CW-1:0] contact;
        logic signed [2:0][CW-1:0] push;
    } t_res;

    t_state                r_state;
    logic signed [CW-1:0]  r_a [3];
    logic signed [CW-1:0]  r_b [3];
    logic [BW-1:0]         r_box;
    logic [SW-1:0]         r_step;
    logic [NW-1:0]         r_best_t;
    logic [IW-1:0]         r_best_idx;
    logic [1:0]            r_best_axis;
    logic                  r_found;
    logic signed [PRW-1:0] r_prod [3];
    t_res                  r_res;
    t_res                  r_out;
    logic                  r_out_valid;

    t_box                  w_box [BOX_COUNT];
    t_box                  w_wdata;
    logic                  w_in_acc;
    logic                  w_last;

    logic signed [DW-1:0]  w_d  [3];
    logic signed [DW-1:0]  w_lo [3];
    logic signed [DW-1:0]  w_hi [3];
    logic signed [DW-1:0]  w_nn [3];
    logic signed [DW-1:0]  w_nf [3];
    logic [DW-1:0]         w_dd [3];
    logic [DW-1:0]         w_dd2 [3];
    logic                  w_dzero [3];
    logic                  w_outside [3];
    logic [TW-1:0]         w_qn [3];
    logic [TW-1:0]         w_qf [3];
    logic                  w_rn [3];
    logic                  w_rf [3];
    logic [NW-1:0]         w_tn [3];
    logic signed [NW:0]    w_tf [3];

    logic [NW-1:0]         w_t0;
    logic signed [NW:0]    w_t1;
    logic [1:0]            w_ax;
    logic                  w_axf;
    logic                  w_rej;
    logic                  w_hit;

    logic signed [PRW-1:0] w_c [3];
    logic signed [PRW-1:0] w_p [3];
    t_res                  n_res;

    assign w_in_acc   = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = r_state != S_IDLE;
    assign w_last     = r_box == BW'(BOX_COUNT - 1);

    always_comb begin
        w_wdata.valid = 1'b1;
        w_wdata.open  = i_box_open;
        w_wdata.lo    = {i_point_a_z, i_point_a_y, i_point_a_x};
        w_wdata.hi    = {i_point_b_z, i_point_b_y, i_point_b_x};
    end

    for (genvar gi = 0; gi < BOX_COUNT; gi++) begin : g_cell
        nsbh_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (r_state == S_EVAL),
            .i_write (w_in_acc && (i_action == ACT_WRITE)
                      && ({1'b0, i_box_index} == (IW+1)'(gi))),
            .i_next  (w_box[(gi + 1) % BOX_COUNT]),
            .i_wdata (w_wdata),
            .o_box   (w_box[gi])
        );
    end

    // slab setup per axis against the box at the head of the ring
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_d[k]     = DW'(r_b[k]) - DW'(r_a[k]);
            w_lo[k]    = DW'($signed(w_box[0].lo[k]));
            w_hi[k]    = DW'($signed(w_box[0].hi[k]));
            w_dzero[k] = w_d[k] == '0;
            if (w_d[k] > 0) begin
                w_nn[k] = (w_lo[k] < w_hi[k]) ? w_lo[k] - DW'(r_a[k])
                                               : w_hi[k] - DW'(r_a[k]);
                w_nf[k] = (w_lo[k] < w_hi[k]) ? w_hi[k] - DW'(r_a[k])
                                               : w_lo[k] - DW'(r_a[k]);
                w_dd[k] = $unsigned(w_d[k]);
            end else begin
                w_nn[k] = (w_lo[k] > w_hi[k]) ? DW'(r_a[k]) - w_lo[k]
                                               : DW'(r_a[k]) - w_hi[k];
                w_nf[k] = (w_lo[k] > w_hi[k]) ? DW'(r_a[k]) - w_hi[k]
                                               : DW'(r_a[k]) - w_lo[k];
                w_dd[k] = $unsigned(-w_d[k]);
            end
            w_dd2[k]     = {w_dd[k][DW-2:0], 1'b0};
            w_outside[k] = (DW'(r_a[k]) < w_lo[k]) || (DW'(r_a[k]) > w_hi[k]);
        end
    end

    for (genvar gk = 0; gk < 3; gk++) begin : g_axis
        nsbh_div u_div_near (
            .i_clk    (i_clk),
            .i_load   (r_state == S_LOAD),
            .i_step   (r_state == S_DIV),
            .i_num    ($unsigned(w_nn[gk])),
            .i_den    (w_dd[gk]),
            .o_quot   (w_qn[gk]),
            .o_rem_nz (w_rn[gk])
        );
        nsbh_div u_div_far (
            .i_clk    (i_clk),
            .i_load   (r_state == S_LOAD),
            .i_step   (r_state == S_DIV),
            .i_num    ($unsigned(w_nf[gk])),
            .i_den    (w_dd[gk]),
            .o_quot   (w_qf[gk]),
            .o_rem_nz (w_rf[gk])
        );
    end

    // round and saturate, then combine axes
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (w_nn[k] <= 0) begin
                w_tn[k] = '0;
            end else if ($unsigned(w_nn[k]) >= w_dd2[k]) begin
                w_tn[k] = ONE_T + NW'(1);
            end else if (NW'(w_qn[k]) + NW'(w_rn[k]) > ONE_T + NW'(1)) begin
                w_tn[k] = ONE_T + NW'(1);
            end else begin
                w_tn[k] = NW'(w_qn[k]) + NW'(w_rn[k]);
            end
            if (w_nf[k] < 0) begin
                w_tf[k] = -(NW+1)'(1);
            end else if (w_nf[k] == '0) begin
                w_tf[k] = '0;
            end else if ($unsigned(w_nf[k]) >= w_dd2[k]
                         || NW'(w_qf[k]) > ONE_T) begin
                w_tf[k] = $signed({1'b0, ONE_T});
            end else begin
                w_tf[k] = $signed({1'b0, NW'(w_qf[k])});
            end
        end
        w_t0  = '0;
        w_t1  = $signed({1'b0, ONE_T});
        w_ax  = 2'd0;
        w_axf = 1'b0;
        w_rej = 1'b0;
        for (int k = 0; k < 3; k++) begin
            if (w_dzero[k]) begin
                w_rej = w_rej | w_outside[k];
            end else begin
                if (w_tn[k] > w_t0) begin
                    w_t0  = w_tn[k];
                    w_ax  = 2'(k);
                    w_axf = 1'b1;
                end
                if (w_tf[k] < w_t1) begin
                    w_t1 = w_tf[k];
                end
            end
        end
        w_hit = w_box[0].valid && !w_box[0].open && !w_rej && w_axf
                && ($signed({1'b0, w_t0}) <= w_t1) && (w_t0 <= ONE_T)
                && (w_t0 < r_best_t);
    end

    // hit point and push from registered products
    always_comb begin
        n_res = '0;
        for (int k = 0; k < 3; k++) begin
            w_c[k] = PRW'(r_a[k]) + ((r_prod[k] + HALF) >>> PARAM_FRAC_BITS);
            w_p[k] = w_c[k] - PRW'(r_b[k]);
            n_res.contact[k] = CW'(w_c[k]);
            if (w_p[k] > P_MAX) begin
                n_res.push[k] = CW'(P_MAX);
            end else if (w_p[k] < P_MIN) begin
                n_res.push[k] = CW'(P_MIN);
            end else begin
                n_res.push[k] = CW'(w_p[k]);
            end
        end
        n_res.hit_flag = 1'b1;
        n_res.entry    = r_best_idx;
        n_res.param    = PW'(r_best_t);
        n_res.axis     = r_best_axis;
        n_res.neg      = r_b[r_best_axis] > r_a[r_best_axis];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_box       <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_RESULT && (!r_out_valid || !i_out_stall)) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_a[0] <= i_point_a_x;
                        r_a[1] <= i_point_a_y;
                        r_a[2] <= i_point_a_z;
                        r_b[0] <= i_point_b_x;
                        r_b[1] <= i_point_b_y;
                        r_b[2] <= i_point_b_z;
                        r_best_t <= ONE_T + NW'(1);
                        r_found  <= 1'b0;
                        r_box    <= '0;
                        r_res    <= '0;
                        r_state  <= (i_action == ACT_PROBE) ? S_LOAD : S_RESULT;
                    end
                end
                S_LOAD: begin
                    r_step  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_step == SW'(PARAM_FRAC_BITS - 1)) begin
                        r_state <= S_EVAL;
                    end else begin
                        r_step <= r_step + SW'(1);
                    end
                end
                S_EVAL: begin
                    if (w_hit) begin
                        r_best_t    <= w_t0;
                        r_best_idx  <= IW'(r_box);
                        r_best_axis <= w_ax;
                        r_found     <= 1'b1;
                    end
                    r_box   <= w_last ? '0 : r_box + BW'(1);
                    r_state <= w_last ? S_MUL : S_LOAD;
                end
                S_MUL: begin
                    for (int k = 0; k < 3; k++) begin
                        r_prod[k] <= PRW'(w_d[k]) * PRW'($signed({1'b0, r_best_t}));
                    end
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (r_found) begin
                        r_res <= n_res;
                    end
                    r_state <= S_RESULT;
                end
                S_RESULT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out   <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_hit_flag        = r_out.hit_flag;
    assign o_hit_entry       = r_out.entry;
    assign o_hit_param       = r_out.param;
    assign o_hit_axis        = r_out.axis;
    assign o_normal_negative = r_out.neg;
    assign o_contact_x       = r_out.contact[0];
    assign o_contact_y       = r_out.contact[1];
    assign o_contact_z       = r_out.contact[2];
    assign o_push_x          = r_out.push[0];
    assign o_push_y          = r_out.push[1];
    assign o_push_z          = r_out.push[2];

    a_acc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> o_in_stall)
        else $error("accepted word did not make the block busy");

    a_ring_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_box == '0))
        else $error("box ring not aligned at idle");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_hit_flag) |-> (o_hit_param == '0 && o_hit_entry == '0
            && o_contact_x == '0 && o_push_z == '0))
        else $error("miss result carries nonzero fields");

    a_param_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_hit_flag) |-> (o_hit_param <= PW'(ONE_T)))
        else $error("hit parameter beyond one");

    a_far_exact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL) |-> !((w_nf[0] == '0 && w_rf[0])
            || (w_nf[1] == '0 && w_rf[1]) || (w_nf[2] == '0 && w_rf[2])))
        else $error("far divider left a remainder on a zero numerator");

endmodule

// ===== bench/tb_nearest_segment_box_hit.sv =====
// Self-checking bench for nearest_segment_box_hit: box writes and segment probes,
// each result checked against an in-bench slab-test predictor. Depends on nsbh_pkg.
module tb_nearest_segment_box_hit;
    import nsbh_pkg::*;

    localparam int  STALL_LIMIT = 12000;
    localparam int  LONG_HOLD   = 2000;
    localparam int  RAND_WORDS  = 1130;
    localparam longint T_ONE    = longint'(1) << PARAM_FRAC_BITS;

    typedef struct {
        logic                 act;
        logic [IW-1:0]        idx;
        logic signed [CW-1:0] pa [3];
        logic signed [CW-1:0] pb [3];
        logic                 opn;
        logic                 zero_res;
    } word_t;

    typedef struct {
        logic                 flag;
        logic [IW-1:0]        entry;
        logic [PW-1:0]        param;
        logic [1:0]           axis;
        logic                 neg;
        logic signed [CW-1:0] contact [3];
        logic signed [CW-1:0] push [3];
    } hit_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic                 i_action;
    logic [IW-1:0]        i_box_index;
    logic signed [CW-1:0] i_point_a_x, i_point_a_y, i_point_a_z;
    logic signed [CW-1:0] i_point_b_x, i_point_b_y, i_point_b_z;
    logic                 i_box_open;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic                 o_hit_flag;
    logic [IW-1:0]        o_hit_entry;
    logic [PW-1:0]        o_hit_param;
    logic [1:0]           o_hit_axis;
    logic                 o_normal_negative;
    logic signed [CW-1:0] o_contact_x, o_contact_y, o_contact_z;
    logic signed [CW-1:0] o_push_x, o_push_y, o_push_z;

    nearest_segment_box_hit u_top (.*);

    longint box_lo [BOX_COUNT][3];
    longint box_hi [BOX_COUNT][3];
    bit     box_opn [BOX_COUNT];
    bit     box_vld [BOX_COUNT];

    hit_t   hit_q [$];
    word_t  dir_q [$];
    int     err_cnt;
    int     idle_cnt;
    bit     long_hold_req;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic longint fdiv(longint n, longint d);
        longint q;
        q = n / d;
        if (n % d != 0 && n < 0) q--;
        return q;
    endfunction

    function automatic longint cdiv(longint n, longint d);
        longint q;
        q = n / d;
        if (n % d != 0 && n > 0) q++;
        return q;
    endfunction

    function automatic longint slab_entry(longint a[3], longint b[3], int bi, output int ax);
        longint t0, t1, d, n1, n2, nn, nf, dd, tn, tf;
        t0 = 0;
        t1 = T_ONE;
        ax = -1;
        for (int k = 0; k < 3; k++) begin
            d = b[k] - a[k];
            if (d == 0) begin
                if (a[k] < box_lo[bi][k] || a[k] > box_hi[bi][k]) return -1;
                continue;
            end
            if (d > 0) begin
                n1 = box_lo[bi][k] - a[k];
                n2 = box_hi[bi][k] - a[k];
                dd = d;
            end else begin
                n1 = a[k] - box_lo[bi][k];
                n2 = a[k] - box_hi[bi][k];
                dd = -d;
            end
            nn = (n1 < n2) ? n1 : n2;
            nf = (n1 < n2) ? n2 : n1;
            tn = cdiv(nn * T_ONE, dd);
            tf = fdiv(nf * T_ONE, dd);
            if (tn < 0) tn = 0;
            if (tn > T_ONE + 1) tn = T_ONE + 1;
            if (tf < -1) tf = -1;
            if (tf > T_ONE) tf = T_ONE;
            if (tn > t0) begin
                t0 = tn;
                ax = k;
            end
            if (tf < t1) t1 = tf;
            if (t0 > t1) return -1;
        end
        if (ax < 0) return -1;
        return t0;
    endfunction

    function automatic hit_t nearest_hit(word_t w);
        hit_t   r;
        longint a[3], b[3];
        longint best_t, t, d, c, p;
        int     best, best_ax, ax;
        r = '{default: '0, contact: '{default: '0}, push: '{default: '0}};
        for (int k = 0; k < 3; k++) begin
            a[k] = longint'(w.pa[k]);
            b[k] = longint'(w.pb[k]);
        end
        if (w.act == ACT_WRITE) begin
            if (int'(w.idx) < BOX_COUNT) begin
                for (int k = 0; k < 3; k++) begin
                    box_lo[w.idx][k] = a[k];
                    box_hi[w.idx][k] = b[k];
                end
                box_opn[w.idx] = w.opn;
                box_vld[w.idx] = 1'b1;
            end
            return r;
        end
        best_t  = T_ONE + 1;
        best    = -1;
        best_ax = 0;
        for (int i = 0; i < BOX_COUNT; i++) begin
            if (!box_vld[i] || box_opn[i]) continue;
            t = slab_entry(a, b, i, ax);
            if (t >= 0 && t <= T_ONE && t < best_t) begin
                best_t  = t;
                best    = i;
                best_ax = ax;
            end
        end
        if (best < 0) return r;
        r.flag  = 1'b1;
        r.entry = best[IW-1:0];
        r.param = best_t[PW-1:0];
        r.axis  = best_ax[1:0];
        r.neg   = b[best_ax] > a[best_ax];
        for (int k = 0; k < 3; k++) begin
            d = b[k] - a[k];
            c = a[k] + fdiv(d * best_t + (T_ONE >> 1), T_ONE);
            p = c - b[k];
            if (p > 64'sd2147483647) p = 64'sd2147483647;
            if (p < -64'sd2147483648) p = -64'sd2147483648;
            r.contact[k] = c[CW-1:0];
            r.push[k]    = p[CW-1:0];
        end
        return r;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 20);
        return $urandom_range(40, 250);
    endfunction

    function automatic int srange(int lo, int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic word_t mk(logic act, int idx, int ax, int ay, int az,
                                 int bx, int by, int bz, logic opn, logic zr);
        word_t w;
        w.act = act;
        w.idx = idx[IW-1:0];
        w.pa  = '{ax, ay, az};
        w.pb  = '{bx, by, bz};
        w.opn = opn;
        w.zero_res = zr;
        return w;
    endfunction

    function automatic word_t rand_word();
        word_t w;
        int    sz, tmp, r;
        w = mk(ACT_PROBE, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        w.idx = IW'($urandom_range(0, 15));
        w.opn = $urandom_range(0, 4) == 0;
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 28) begin
            w.act = ACT_WRITE;
            for (int k = 0; k < 3; k++) begin
                if (r < 12) begin
                    w.pa[k] = $urandom();
                    w.pb[k] = $urandom();
                end else begin
                    sz = srange(0, 2048);
                    w.pa[k] = srange(-4096, 4096);
                    w.pb[k] = w.pa[k] + sz;
                    if (r < 20) begin
                        tmp = w.pa[k];
                        w.pa[k] = w.pb[k];
                        w.pb[k] = tmp;
                    end
                end
            end
        end else begin
            for (int k = 0; k < 3; k++) begin
                if (r < 10) begin
                    w.pa[k] = $urandom();
                    w.pb[k] = $urandom();
                end else begin
                    w.pa[k] = srange(-7000, 7000);
                    w.pb[k] = srange(-7000, 7000);
                end
            end
            if (r >= 10 && r < 25) w.pb[$urandom_range(0, 2)] = w.pa[$urandom_range(0, 2)];
            if (r >= 25 && r < 35) begin
                tmp = $urandom_range(0, 2);
                w.pb[tmp] = w.pa[tmp];
            end
        end
        return w;
    endfunction

    task automatic send(word_t w, int gap);
        hit_t e;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_action    <= w.act;
        i_box_index <= w.idx;
        i_point_a_x <= w.pa[0];
        i_point_a_y <= w.pa[1];
        i_point_a_z <= w.pa[2];
        i_point_b_x <= w.pb[0];
        i_point_b_y <= w.pb[1];
        i_point_b_z <= w.pb[2];
        i_box_open  <= w.opn;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        e = nearest_hit(w);
        if (w.zero_res) e = '{default: '0, contact: '{default: '0}, push: '{default: '0}};
        hit_q.push_back(e);
        @(negedge i_clk);
    endtask

    initial begin
        i_out_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge i_clk);
                long_hold_req = 1'b0;
                i_out_stall <= 1'b0;
            end else if ($urandom_range(0, 2) == 0) begin
                i_out_stall <= 1'b1;
                repeat (gap_len()) @(negedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
                repeat ($urandom_range(0, 40)) @(negedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        hit_t e;
        logic signed [CW-1:0] gc [3];
        logic signed [CW-1:0] gp [3];
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            gc = '{o_contact_x, o_contact_y, o_contact_z};
            gp = '{o_push_x, o_push_y, o_push_z};
            if (hit_q.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10) $display("ERROR: unexpected result word at %0t", $time);
            end else begin
                e = hit_q.pop_front();
                if (e.flag !== o_hit_flag || e.entry !== o_hit_entry
                        || e.param !== o_hit_param || e.axis !== o_hit_axis
                        || e.neg !== o_normal_negative || e.contact != gc || e.push != gp) begin
                    err_cnt++;
                    if (err_cnt <= 10) begin
                        $display("ERROR at %0t: exp hit=%0d ent=%0d t=%0h ax=%0d neg=%0d",
                                 $time, e.flag, e.entry, e.param, e.axis, e.neg);
                        $display("  exp c=%0d,%0d,%0d p=%0d,%0d,%0d", e.contact[0],
                                 e.contact[1], e.contact[2], e.push[0], e.push[1], e.push[2]);
                        $display("  got hit=%0d ent=%0d t=%0h ax=%0d neg=%0d", o_hit_flag,
                                 o_hit_entry, o_hit_param, o_hit_axis, o_normal_negative);
                        $display("  got c=%0d,%0d,%0d p=%0d,%0d,%0d", gc[0], gc[1], gc[2],
                                 gp[0], gp[1], gp[2]);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                idle_cnt <= 0;
            end else if (idle_cnt >= STALL_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end else begin
                idle_cnt <= idle_cnt + 1;
            end
        end
    end

    initial begin
        int mn, mx;
        mn = 32'h8000_0000;
        mx = 32'h7fff_ffff;
        err_cnt = 0;
        idle_cnt = 0;
        long_hold_req = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_action = ACT_WRITE;
        i_box_index = '0;
        {i_point_a_x, i_point_a_y, i_point_a_z} = '0;
        {i_point_b_x, i_point_b_y, i_point_b_z} = '0;
        i_box_open = 1'b0;

        dir_q.push_back(mk(ACT_PROBE, 0, 0, 0, 0, 256, 256, 256, 1, 1));
        dir_q.push_back(mk(ACT_WRITE, 0, 256, 256, 256, 512, 512, 512, 0, 1));
        dir_q.push_back(mk(ACT_WRITE, 15, mn, mn, mn, mx, mx, mx, 1, 1));
        dir_q.push_back(mk(ACT_PROBE, 7, 0, 0, 0, 1024, 1024, 1024, 0, 0));
        dir_q.push_back(mk(ACT_PROBE, 0, 300, 300, 300, 1000, 1000, 1000, 0, 1));
        dir_q.push_back(mk(ACT_PROBE, 0, 0, 0, 0, 0, 1024, 1024, 0, 1));
        dir_q.push_back(mk(ACT_PROBE, 0, 1024, 384, 384, 0, 384, 384, 0, 0));
        dir_q.push_back(mk(ACT_WRITE, 1, 900, 0, 0, 700, 1024, 1024, 0, 1));
        dir_q.push_back(mk(ACT_PROBE, 0, 2000, 500, 500, 0, 500, 500, 0, 0));
        dir_q.push_back(mk(ACT_WRITE, 2, 256, 256, 256, 512, 512, 512, 0, 1));
        dir_q.push_back(mk(ACT_PROBE, 0, 0, 0, 0, 1024, 1024, 1024, 0, 0));
        dir_q.push_back(mk(ACT_WRITE, 0, 256, 256, 256, 512, 512, 512, 1, 1));
        dir_q.push_back(mk(ACT_PROBE, 0, 0, 0, 0, 1024, 1024, 1024, 0, 0));
        dir_q.push_back(mk(ACT_WRITE, 3, 0, 0, 0, 256, 256, 256, 0, 1));
        dir_q.push_back(mk(ACT_PROBE, 0, mn, mn, mn, mx, mx, mx, 0, 0));
        dir_q.push_back(mk(ACT_PROBE, 0, mx, mx, mx, mn, mn, mn, 0, 0));
        dir_q.push_back(mk(ACT_PROBE, 0, mx, 128, 128, mn, 128, 128, 0, 0));
        dir_q.push_back(mk(ACT_WRITE, 15, mn, mn, mn, mx, mx, mx, 0, 1));
        dir_q.push_back(mk(ACT_PROBE, 0, 0, 0, 0, 256, 256, 256, 0, 0));
        dir_q.push_back(mk(ACT_WRITE, 15, 0, 0, 0, 0, 0, 0, 0, 1));
        dir_q.push_back(mk(ACT_PROBE, 0, -256, 0, 0, 256, 0, 0, 0, 0));
        dir_q.push_back(mk(ACT_PROBE, 0, 5000, 5000, 5000, 6000, 6000, 6000, 0, 1));

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_q[i]) send(dir_q[i], gap_len());
        for (int n = 0; n < RAND_WORDS; n++) begin
            if (n == 300) long_hold_req = 1'b1;
            if (n == 600) begin
                i_in_valid <= 1'b0;
                wait (hit_q.size() == 0);
                repeat (10) @(negedge i_clk);
            end
            send(rand_word(), (n % 200 < 40) ? 0 : gap_len());
        end
        i_in_valid <= 1'b0;
        wait (hit_q.size() == 0);
        repeat (400) @(posedge i_clk);
        if (err_cnt == 0 && hit_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== nearest_segment_box_hit.f =====
hw/rtl/nsbh_pkg.sv
hw/rtl/nsbh_cell.sv
hw/rtl/nsbh_div.sv
hw/rtl/nearest_segment_box_hit.sv
bench/tb_nearest_segment_box_hit.sv
